// ===== design/lzpe_pkg.sv =====
// Package for the LZ78 phrase encoder.
// Holds the sequencer state type and the control word sent to the dictionary cells.
// No dependencies.
`default_nettype none

package lzpe_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SWEEP,
    ST_DECIDE
  } lzpe_state_t;

  typedef struct packed {
    logic load;
    logic sweep;
    logic write;
  } lzpe_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/lzpe_cell.sv =====
// One dictionary cell of the LZ78 phrase encoder: holds one entry, compares it
// against the broadcast query and passes its hit index toward cell zero.
// Depends on lzpe_pkg.
`default_nettype none

module lzpe_cell
  import lzpe_pkg::*;
#(
  parameter int INDEX       = 0,
  parameter int IDX_W       = 11,
  parameter int SYMBOL_BITS = 16
) (
  input  wire logic                   clk,
  input  wire lzpe_cell_ctrl_t        ctrl,
  input  wire logic [IDX_W-1:0]       count,
  input  wire logic [IDX_W-1:0]       query_prefix,
  input  wire logic [SYMBOL_BITS-1:0] query_symbol,
  input  wire logic [IDX_W-1:0]       chain_in,
  output logic      [IDX_W-1:0]       chain_out
);

  logic [IDX_W-1:0]       entry_prefix;
  logic [SYMBOL_BITS-1:0] entry_symbol;
  logic [IDX_W-1:0]       hit_index;
  logic                   valid;
  logic                   match;

  assign valid = IDX_W'(INDEX) < count;
  assign match = valid && (entry_prefix == query_prefix) && (entry_symbol == query_symbol);

  always_ff @(posedge clk) begin
    if (ctrl.write && (count == IDX_W'(INDEX))) begin
      entry_prefix <= query_prefix;
      entry_symbol <= query_symbol;
    end
  end

  // Entries are unique, so at most one cell loads a nonzero index and an OR merges the chain.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hit_index <= match ? IDX_W'(INDEX + 1) : '0;
    end else if (ctrl.sweep) begin
      hit_index <= hit_index | chain_in;
    end
  end

  assign chain_out = hit_index;

endmodule

`default_nettype wire

// ===== design/lz78_phrase_encoder.sv =====
// LZ78 phrase encoder: a sequencer in front of a row of dictionary cells.
// Steps: accept in idle, a load step, sweep steps (if more than one entry is held) as the
// hit index walks down the cell row, then a decide step; if the phrase ends, the pair is
// registered as the decide step goes ahead. A new word is taken only back in idle, and the
// decide step waits while an earlier pair is still held at the output and a pair is to be sent.
// Reset clears the phrase, entry count, sequencer and output valid; entries are not cleared.
`default_nettype none

module lz78_phrase_encoder
  import lzpe_pkg::*;
#(
  parameter int DICT_ENTRIES = 1024,
  parameter int SYMBOL_BITS  = 16,
  localparam int IDX_W = $clog2(DICT_ENTRIES + 1),
  localparam int IN_W  = ((SYMBOL_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((IDX_W + SYMBOL_BITS + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // symbol
  input  wire logic             s_tlast,   // last_symbol
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata,   // prefix_index, next_symbol
  output logic                  m_tlast,   // end_of_message
  output logic                  m_tuser    // dictionary_full
);

  lzpe_state_t            state, state_next;
  lzpe_cell_ctrl_t        ctrl;
  logic [IDX_W-1:0]       phrase;
  logic [IDX_W-1:0]       count;
  logic [IDX_W-1:0]       left;
  logic [SYMBOL_BITS-1:0] sym;
  logic                   last;
  logic [IDX_W-1:0]       out_prefix;
  logic [SYMBOL_BITS-1:0] out_symbol;
  logic [IDX_W-1:0]       chain [DICT_ENTRIES+1];
  logic [IDX_W-1:0]       hit;
  logic                   emit;
  logic                   can_go;
  logic                   full;
  logic                   write;
  logic                   decide_go;

  assign chain[DICT_ENTRIES] = '0;

  for (genvar i = 0; i < DICT_ENTRIES; i++) begin : g_cell
    lzpe_cell #(
      .INDEX      (i),
      .IDX_W      (IDX_W),
      .SYMBOL_BITS(SYMBOL_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .query_prefix(phrase),
      .query_symbol(sym),
      .chain_in    (chain[i+1]),
      .chain_out   (chain[i])
    );
  end

  assign hit       = chain[0];
  assign emit      = (hit == '0) || last;
  assign can_go    = !emit || !m_tvalid || m_tready;
  assign full      = (hit == '0) && (count >= IDX_W'(DICT_ENTRIES));
  assign decide_go = (state == ST_DECIDE) && can_go;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        state_next = (count > IDX_W'(1)) ? ST_SWEEP : ST_DECIDE;
      end
      ST_SWEEP: begin
        if (left == IDX_W'(1)) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (can_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.sweep = 1'b0;
    write      = 1'b0;
    unique case (state)
      ST_IDLE:   s_tready   = 1'b1;
      ST_LOAD:   ctrl.load  = 1'b1;
      ST_SWEEP:  ctrl.sweep = 1'b1;
      ST_DECIDE: write      = can_go && (hit == '0) && !full;
      default:   s_tready   = 1'b0;
    endcase
    ctrl.write = write;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phrase   <= '0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (decide_go) begin
        phrase <= emit ? '0 : hit;
        if (emit && last) begin
          count <= '0;
        end else if (write) begin
          count <= count + IDX_W'(1);
        end
      end
      if (decide_go && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sym  <= s_tdata[SYMBOL_BITS-1:0];
      last <= s_tlast;
    end
    if (state == ST_LOAD) begin
      left <= count - IDX_W'(1);
    end else if (state == ST_SWEEP) begin
      left <= left - IDX_W'(1);
    end
    if (decide_go && emit) begin
      out_prefix <= phrase;
      out_symbol <= sym;
      m_tlast    <= last;
      m_tuser    <= full;
    end
  end

  assign m_tdata = OUT_W'({out_symbol, out_prefix});

endmodule

`default_nettype wire

// ===== design/lzpe_checker.sv =====
// Port-level checker for the LZ78 phrase encoder, bound to the top level.
// Depends on lz78_phrase_encoder.
`default_nettype none

module lzpe_checker #(
  parameter int IN_W  = 16,
  parameter int OUT_W = 32
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic [IN_W-1:0]  s_tdata,
  input wire logic             s_tlast,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata,
  input wire logic             m_tlast,
  input wire logic             m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
    else $error("input accepted again before the lookup finished");

  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("result word appeared while the encoder was busy");

  a_no_result_at_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result word appeared right after an accept");

  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !$isunknown({s_tdata, s_tlast}))
    else $error("input word accepted with unknown bits");

endmodule

bind lz78_phrase_encoder lzpe_checker #(
  .IN_W (IN_W),
  .OUT_W(OUT_W)
) u_lzpe_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .s_tlast (s_tlast),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast),
  .m_tuser (m_tuser)
);

`default_nettype wire
